@@ rtl/time_window_single_resource_scheduler_unit_defines.svh @@
// Assertion macros for the time window scheduler.
`ifndef TIME_WINDOW_SINGLE_RESOURCE_SCHEDULER_UNIT_DEFINES_SVH
`define TIME_WINDOW_SINGLE_RESOURCE_SCHEDULER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TWSRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");
`define TWSRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define TWSRS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TWSRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/twsrs_pkg.sv @@
// Types and constants shared by the time window scheduler modules.
package twsrs_pkg;

  localparam int ID_W   = 32;
  localparam int TIME_W = 40;
  localparam int STAT_W = 3;
  localparam int SLOT_W = 4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [STAT_W-1:0] ST_PENDING   = 3'd0;
  localparam logic [STAT_W-1:0] ST_RECORDING = 3'd1;
  localparam logic [STAT_W-1:0] ST_CANCELLED = 3'd5;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_MISS  = 2'd2,
    ACT_START = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SCAN,
    SC_DRAIN,
    SC_FLUSH
  } scan_state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] stop_time;
    logic [STAT_W-1:0] status;
  } entry_t;

endpackage

@@ rtl/twsrs_table.sv @@
// Schedule table memory with per-slot valid bits and a count of recording entries.
module twsrs_table import twsrs_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  output logic          rec_any
);

  localparam int CW = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  entry_t             rd_q_r;
  logic               rd_vld_r;
  logic [DEPTH-1:0]   vld_r;
  logic [DEPTH-1:0]   rec_r;
  logic [DEPTH-1:0]   rec_nxt;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      cnt_nxt;
  logic               new_rec;
  logic               old_rec;

  assign new_rec = (wr_data.status == ST_RECORDING);
  assign old_rec = rec_r[wr_addr];

  always_comb begin
    rec_nxt = rec_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      rec_nxt[wr_addr] = new_rec;
      if (new_rec && !old_rec) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (!new_rec && old_rec) begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rec_r    <= '0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rec_r <= rec_nxt;
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_comb begin
    rd_data = rd_q_r;
    if (!rd_vld_r) begin
      rd_data.status = ST_CANCELLED;
    end
  end

  assign rec_any = (cnt_r != '0);

endmodule

@@ rtl/twsrs_scan.sv @@
// Tick sequencer: walks the table, decides actions and emits result beats.
module twsrs_scan import twsrs_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_go,
  input  logic [TIME_W-1:0] tick_now,
  input  logic              tick_manual,
  input  logic              rec_any,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  entry_t            rd_data,
  output logic              busy,
  output logic              out_valid,
  output logic [1:0]        out_action,
  output logic [SLOT_W-1:0] out_slot,
  output logic [ID_W-1:0]   out_id,
  output logic              out_last
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  scan_state_t        state_r, state_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic               rbusy_r, rbusy_nxt;
  logic               eval_v_r, eval_v_nxt;
  logic [AW-1:0]      eval_slot_r, eval_slot_nxt;
  logic               hold_v_r, hold_v_nxt;
  act_t               hold_act_r, hold_act_nxt;
  logic [SLOT_W-1:0]  hold_slot_r, hold_slot_nxt;
  logic [ID_W-1:0]    hold_id_r, hold_id_nxt;
  logic               ov_r, ov_nxt;
  act_t               oact_r, oact_nxt;
  logic [SLOT_W-1:0]  oslot_r, oslot_nxt;
  logic [ID_W-1:0]    oid_r, oid_nxt;
  logic               olast_r, olast_nxt;
  act_t               act;
  logic               stop_due;
  logic               in_window;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE: begin
        if (tick_go) begin
          state_nxt = SC_SCAN;
        end
      end
      SC_SCAN: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = SC_DRAIN;
        end
      end
      SC_DRAIN: state_nxt = SC_FLUSH;
      SC_FLUSH: state_nxt = SC_IDLE;
      default:  state_nxt = SC_IDLE;
    endcase
  end

  assign stop_due  = (now_r >= rd_data.stop_time);
  assign in_window = (now_r >= rd_data.start_time);

  always_comb begin
    act = ACT_NONE;
    if (eval_v_r) begin
      if (rd_data.status == ST_RECORDING) begin
        if (stop_due) begin
          act = ACT_STOP;
        end
      end else if (rd_data.status == ST_PENDING) begin
        if (stop_due) begin
          act = ACT_MISS;
        end else if (in_window && !rbusy_r) begin
          act = ACT_START;
        end
      end
    end
  end

  always_comb begin
    addr_nxt      = addr_r;
    now_nxt       = now_r;
    rbusy_nxt     = rbusy_r;
    eval_v_nxt    = 1'b0;
    eval_slot_nxt = addr_r;
    hold_v_nxt    = hold_v_r;
    hold_act_nxt  = hold_act_r;
    hold_slot_nxt = hold_slot_r;
    hold_id_nxt   = hold_id_r;
    ov_nxt        = 1'b0;
    oact_nxt      = oact_r;
    oslot_nxt     = oslot_r;
    oid_nxt       = oid_r;
    olast_nxt     = olast_r;
    rd_en         = 1'b0;
    rd_addr       = addr_r;
    case (state_r)
      SC_IDLE: begin
        if (tick_go) begin
          addr_nxt   = '0;
          now_nxt    = tick_now;
          rbusy_nxt  = tick_manual || rec_any;
          hold_v_nxt = 1'b0;
        end
      end
      SC_SCAN: begin
        rd_en      = 1'b1;
        eval_v_nxt = 1'b1;
        addr_nxt   = addr_r + AW'(1);
      end
      SC_FLUSH: begin
        ov_nxt     = 1'b1;
        olast_nxt  = 1'b1;
        hold_v_nxt = 1'b0;
        if (hold_v_r) begin
          oact_nxt  = hold_act_r;
          oslot_nxt = hold_slot_r;
          oid_nxt   = hold_id_r;
        end else begin
          oact_nxt  = ACT_NONE;
          oslot_nxt = '0;
          oid_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
    if (act != ACT_NONE) begin
      if (hold_v_r) begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b0;
        oact_nxt  = hold_act_r;
        oslot_nxt = hold_slot_r;
        oid_nxt   = hold_id_r;
      end
      hold_v_nxt    = 1'b1;
      hold_act_nxt  = act;
      hold_slot_nxt = SLOT_W'(eval_slot_r);
      hold_id_nxt   = rd_data.id;
      if (act == ACT_START) begin
        rbusy_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SC_IDLE;
      eval_v_r <= 1'b0;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      eval_v_r <= eval_v_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    now_r       <= now_nxt;
    rbusy_r     <= rbusy_nxt;
    eval_slot_r <= eval_slot_nxt;
    hold_act_r  <= hold_act_nxt;
    hold_slot_r <= hold_slot_nxt;
    hold_id_r   <= hold_id_nxt;
    oact_r      <= oact_nxt;
    oslot_r     <= oslot_nxt;
    oid_r       <= oid_nxt;
    olast_r     <= olast_nxt;
  end

  assign busy       = (state_r != SC_IDLE);
  assign out_valid  = ov_r;
  assign out_action = oact_r;
  assign out_slot   = oslot_r;
  assign out_id     = oid_r;
  assign out_last   = olast_r;

endmodule

@@ rtl/time_window_single_resource_scheduler_unit.sv @@
// Top level of the single resource time window scheduler.
//
// Items are presented on the in_ ports and taken when start is high and busy
// is low. A write item (in_func low) loads one table slot
// and produces no result; busy stays low, so another item may follow at once.
// Writes to slots at or beyond the table depth are dropped.
// A tick item (in_func high) walks the table one slot per cycle through the
// synchronous table memory; busy stays high through the scan, drain and flush.
// Results appear one per cycle on the out_ ports while out_valid is high; the
// last beat of a tick has out_last set, and a tick with nothing to do gives a
// single beat with action none. The final beat is on the out_ ports in the
// first cycle with busy low. The receiver cannot hold results off, so beats
// are never stalled. The block never alters a status itself; the host writes
// statuses back. Reset clears every slot to the cancelled state through
// per-slot valid bits, so no clearing pass is needed and the block is ready
// right after reset.
`include "time_window_single_resource_scheduler_unit_defines.svh"
module time_window_single_resource_scheduler_unit import twsrs_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [ID_W-1:0]   in_entry_id,
  input  logic [TIME_W-1:0] in_start_time,
  input  logic [TIME_W-1:0] in_stop_time,
  input  logic [STAT_W-1:0] in_status_code,
  input  logic [TIME_W-1:0] in_now,
  input  logic              in_manual_busy,
  output logic              out_valid,
  output logic [1:0]        out_action,
  output logic [SLOT_W-1:0] out_slot_out,
  output logic [ID_W-1:0]   out_id_out,
  output logic              out_last
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic          accept;
  logic          tick_go;
  logic [31:0]   slot_ext;
  logic          wr_ok;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          rec_any;

  assign accept   = start && !busy;
  assign tick_go  = accept && (in_func == FUNC_TICK);
  assign slot_ext = 32'(in_slot);
  assign wr_ok    = (slot_ext < 32'(TABLE_DEPTH));
  assign wr_en    = accept && (in_func == FUNC_WRITE) && wr_ok;
  assign wr_addr  = slot_ext[AW-1:0];

  assign wr_data.id         = in_entry_id;
  assign wr_data.start_time = in_start_time;
  assign wr_data.stop_time  = in_stop_time;
  assign wr_data.status     = in_status_code;

  twsrs_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rec_any (rec_any)
  );

  twsrs_scan #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_go     (tick_go),
    .tick_now    (in_now),
    .tick_manual (in_manual_busy),
    .rec_any     (rec_any),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_action  (out_action),
    .out_slot    (out_slot_out),
    .out_id      (out_id_out),
    .out_last    (out_last)
  );

  `TWSRS_ASSERT_NEXT(a_tick_holds_busy, clk, rst_n, tick_go, busy)
  `TWSRS_ASSERT_NEXT(a_write_stays_free, clk, rst_n, accept && (in_func == FUNC_WRITE), !busy)
  `TWSRS_ASSERT_SAME(a_none_is_last, clk, rst_n, out_valid && (out_action == ACT_NONE), out_last)
  `TWSRS_ASSERT_SAME(a_beat_follows_tick, clk, rst_n, out_valid, $past(busy))
  `TWSRS_ASSERT_SAME(a_no_read_idle, clk, rst_n, rd_en, busy)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the time window scheduler, with directed rows and random rounds.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import twsrs_pkg::*;

  localparam int DEPTH = 16;
  localparam int MAX_BEATS = 16;
  localparam int RANDOM_ITEMS = 95;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RESET_CYCLES = 11;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [STAT_W-1:0] ST_DONE = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISSED = 3'd3;
  localparam logic [STAT_W-1:0] ST_FAILED = 3'd4;
  localparam logic [STAT_W-1:0] ST_SPARE6 = 3'd6;
  localparam logic [STAT_W-1:0] ST_SPARE7 = 3'd7;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_stop;
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] now;
    logic              mb;
  } sched_item_t;

  typedef struct packed {
    act_t              action;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic              last;
  } beat_t;

  typedef struct {
    sched_item_t item;
    bit          typed;
    beat_t       want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_func = 1'b0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [ID_W-1:0]   in_entry_id = '0;
  logic [TIME_W-1:0] in_start_time = '0;
  logic [TIME_W-1:0] in_stop_time = '0;
  logic [STAT_W-1:0] in_status_code = '0;
  logic [TIME_W-1:0] in_now = '0;
  logic              in_manual_busy = 1'b0;
  logic              out_valid;
  logic [1:0]        out_action;
  logic [SLOT_W-1:0] out_slot_out;
  logic [ID_W-1:0]   out_id_out;
  logic              out_last;

  logic [ID_W-1:0]   tbl_id [DEPTH];
  logic [TIME_W-1:0] tbl_start [DEPTH];
  logic [TIME_W-1:0] tbl_stop [DEPTH];
  logic [STAT_W-1:0] tbl_stat [DEPTH];

  beat_t tick_actions[$];
  beat_t awaited_beats[$];
  int    errors = 0;
  int    n_items = 0;
  int    n_writes = 0;
  int    n_ticks = 0;
  int    n_beats = 0;
  int    action_count [4] = '{0, 0, 0, 0};
  int    quiet = 0;
  bit    steady = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  time_window_single_resource_scheduler_unit #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_entry_id    (in_entry_id),
    .in_start_time  (in_start_time),
    .in_stop_time   (in_stop_time),
    .in_status_code (in_status_code),
    .in_now         (in_now),
    .in_manual_busy (in_manual_busy),
    .out_valid      (out_valid),
    .out_action     (out_action),
    .out_slot_out   (out_slot_out),
    .out_id_out     (out_id_out),
    .out_last       (out_last)
  );

  initial begin
    for (int s = 0; s < DEPTH; s++) begin
      tbl_id[s] = '0;
      tbl_start[s] = '0;
      tbl_stop[s] = '0;
      tbl_stat[s] = ST_CANCELLED;
    end
  end

  function automatic void schedule_tick(input logic [TIME_W-1:0] now, input logic mb);
    logic  held;
    beat_t b;
    tick_actions.delete();
    held = mb;
    for (int s = 0; s < DEPTH; s++)
      if (tbl_stat[s] == ST_RECORDING) held = 1'b1;
    for (int s = 0; s < DEPTH && tick_actions.size() < MAX_BEATS; s++) begin
      b = '{ACT_NONE, SLOT_W'(s), tbl_id[s], 1'b0};
      if (tbl_stat[s] == ST_RECORDING) begin
        if (now >= tbl_stop[s]) begin
          b.action = ACT_STOP;
          tick_actions = {tick_actions, b};
        end
      end else if (tbl_stat[s] == ST_PENDING) begin
        if (now >= tbl_stop[s]) begin
          b.action = ACT_MISS;
          tick_actions = {tick_actions, b};
        end else if (now >= tbl_start[s] && !held) begin
          b.action = ACT_START;
          tick_actions = {tick_actions, b};
          held = 1'b1;
        end
      end
    end
    if (tick_actions.size() == 0) begin
      b = '{ACT_NONE, '0, '0, 1'b0};
      tick_actions = {tick_actions, b};
    end
    b = tick_actions.pop_back();
    b.last = 1'b1;
    tick_actions = {tick_actions, b};
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    rand_time = {8'($urandom_range(255, 0)), 32'($urandom)};
  endfunction

  function automatic logic [STAT_W-1:0] pick_status();
    int r;
    r = $urandom_range(9, 0);
    if (r < 5) pick_status = ST_PENDING;
    else if (r < 7) pick_status = ST_RECORDING;
    else pick_status = STAT_W'($urandom_range(7, 0));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (steady || r < 55) pick_gap = 0;
    else if (r < 88) pick_gap = $urandom_range(3, 1);
    else pick_gap = $urandom_range(40, 8);
  endfunction

  function automatic sched_item_t noise_item();
    sched_item_t it;
    it.func = 1'($urandom_range(1, 0));
    it.slot = SLOT_W'($urandom_range(15, 0));
    it.id = $urandom;
    it.t_start = rand_time();
    it.t_stop = rand_time();
    it.status = STAT_W'($urandom_range(7, 0));
    it.now = rand_time();
    it.mb = 1'($urandom_range(1, 0));
    return it;
  endfunction

  function automatic dir_row_t row_write(input logic [SLOT_W-1:0] slot, input logic [ID_W-1:0] id,
                                         input logic [TIME_W-1:0] t0, input logic [TIME_W-1:0] t1,
                                         input logic [STAT_W-1:0] status);
    dir_row_t row;
    row.item = '0;
    row.item.func = FUNC_WRITE;
    row.item.slot = slot;
    row.item.id = id;
    row.item.t_start = t0;
    row.item.t_stop = t1;
    row.item.status = status;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t row_tick(input logic [TIME_W-1:0] now, input logic mb);
    dir_row_t row;
    row.item = '0;
    row.item.func = FUNC_TICK;
    row.item.now = now;
    row.item.mb = mb;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t row_tick_sure(input logic [TIME_W-1:0] now, input logic mb,
                                             input act_t act, input logic [SLOT_W-1:0] slot,
                                             input logic [ID_W-1:0] id);
    dir_row_t row;
    row = row_tick(now, mb);
    row.typed = 1'b1;
    row.want = '{act, slot, id, 1'b1};
    return row;
  endfunction

  task automatic issue(input sched_item_t it, input bit typed, input beat_t want);
    in_func <= it.func;
    in_slot <= it.slot;
    in_entry_id <= it.id;
    in_start_time <= it.t_start;
    in_stop_time <= it.t_stop;
    in_status_code <= it.status;
    in_now <= it.now;
    in_manual_busy <= it.mb;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    if (it.func == FUNC_WRITE) begin
      n_writes++;
      tbl_id[it.slot] = it.id;
      tbl_start[it.slot] = it.t_start;
      tbl_stop[it.slot] = it.t_stop;
      tbl_stat[it.slot] = it.status;
      tick_actions.delete();
    end else begin
      n_ticks++;
      schedule_tick(it.now, it.mb);
      if (typed) begin
        tick_actions = {want};
      end
      foreach (tick_actions[k]) begin
        awaited_beats = {awaited_beats, tick_actions[k]};
        action_count[int'(tick_actions[k].action)]++;
      end
    end
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic put_entry(input logic [SLOT_W-1:0] slot, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] t0, input logic [TIME_W-1:0] t1,
                           input logic [STAT_W-1:0] status);
    sched_item_t it;
    it = noise_item();
    it.func = FUNC_WRITE;
    it.slot = slot;
    it.id = id;
    it.t_start = t0;
    it.t_stop = t1;
    it.status = status;
    issue(it, 1'b0, '0);
    pause(pick_gap());
  endtask

  task automatic tick_at(input logic [TIME_W-1:0] now, input logic mb);
    sched_item_t it;
    it = noise_item();
    it.func = FUNC_TICK;
    it.now = now;
    it.mb = mb;
    issue(it, 1'b0, '0);
    pause(pick_gap());
  endtask

  // The host writes the outcome of most actions back, as its firmware would.
  task automatic write_back();
    beat_t             acts[$];
    logic [STAT_W-1:0] next_stat;
    acts = tick_actions;
    foreach (acts[k]) begin
      if (acts[k].action != ACT_NONE && $urandom_range(3, 0) != 0) begin
        case (acts[k].action)
          ACT_START: next_stat = ST_RECORDING;
          ACT_STOP: next_stat = ST_DONE;
          default: next_stat = ST_MISSED;
        endcase
        put_entry(acts[k].slot, tbl_id[acts[k].slot], tbl_start[acts[k].slot],
                  tbl_stop[acts[k].slot], next_stat);
      end
    end
  endtask

  task automatic fill_round();
    logic [TIME_W-1:0] base;
    base = rand_time();
    for (int s = 0; s < DEPTH; s++)
      put_entry(SLOT_W'(s), $urandom, rand_time(), base - TIME_W'($urandom_range(20, 0)),
                $urandom_range(1, 0) ? ST_RECORDING : ST_PENDING);
    tick_at(base, 1'($urandom_range(1, 0)));
    write_back();
  endtask

  task automatic noise_round();
    int k;
    k = $urandom_range(3, 1);
    repeat (k) begin
      issue(noise_item(), 1'b0, '0);
      pause(pick_gap());
    end
  endtask

  task automatic window_round();
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] now;
    int                sel;
    int                k;
    sel = $urandom_range(7, 0);
    if (sel == 0) base = TIME_W'($urandom_range(100, 0));
    else if (sel == 1) base = TIME_MAX - TIME_W'($urandom_range(100, 0));
    else base = rand_time();
    k = $urandom_range(4, 1);
    repeat (k) begin
      t0 = base + TIME_W'($urandom_range(50, 0));
      if ($urandom_range(7, 0) == 0)
        put_entry(SLOT_W'($urandom_range(15, 0)), $urandom, t0,
                  t0 - TIME_W'($urandom_range(30, 0)), ST_PENDING);
      else
        put_entry(SLOT_W'($urandom_range(15, 0)), $urandom, t0,
                  t0 + TIME_W'($urandom_range(60, 1)), pick_status());
    end
    now = base;
    k = $urandom_range(3, 1);
    repeat (k) begin
      now = now + TIME_W'($urandom_range(40, 0));
      tick_at(now, $urandom_range(3, 0) == 0);
      write_back();
    end
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid) begin
      n_beats++;
      if (awaited_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected nothing, actual action %0d slot %0d id %h",
                 $time, out_action, out_slot_out, out_id_out);
      end else begin
        want = awaited_beats.pop_front();
        check_field("action", TIME_W'(want.action), TIME_W'(out_action));
        check_field("slot_out", TIME_W'(want.slot), TIME_W'(out_slot_out));
        check_field("id_out", TIME_W'(want.id), TIME_W'(out_id_out));
        check_field("last", TIME_W'(want.last), TIME_W'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, quiet);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    int       first_random;
    rows = {rows, row_tick_sure('0, 1'b0, ACT_NONE, '0, '0)};
    rows = {rows, row_tick_sure(TIME_MAX, 1'b1, ACT_NONE, '0, '0)};
    rows = {rows, row_write(4'd0, 32'hFFFF_FFFF, '0, TIME_MAX, ST_PENDING)};
    rows = {rows, row_tick_sure('0, 1'b0, ACT_START, 4'd0, 32'hFFFF_FFFF)};
    rows = {rows, row_tick_sure('0, 1'b1, ACT_NONE, '0, '0)};
    rows = {rows, row_tick_sure(TIME_MAX, 1'b0, ACT_MISS, 4'd0, 32'hFFFF_FFFF)};
    rows = {rows, row_write(4'd15, 32'h0, TIME_MAX, TIME_MAX, ST_RECORDING)};
    rows = {rows, row_tick(40'h7F_FFFF_FFFF, 1'b0)};
    rows = {rows, row_tick(TIME_MAX, 1'b0)};
    rows = {rows, row_write(4'd15, 32'h5A5A_A5A5, 40'd1000, 40'd2000, ST_DONE)};
    rows = {rows, row_write(4'd7, 32'h0000_0001, 40'd2000, 40'd1000, ST_PENDING)};
    rows = {rows, row_tick(40'd1500, 1'b0)};
    rows = {rows, row_tick(40'd999, 1'b0)};
    rows = {rows, row_write(4'd1, 32'h1111_0001, 40'd10, 40'd20, ST_MISSED)};
    rows = {rows, row_write(4'd2, 32'h1111_0002, 40'd10, 40'd20, ST_FAILED)};
    rows = {rows, row_write(4'd3, 32'h1111_0003, 40'd10, 40'd20, ST_SPARE6)};
    rows = {rows, row_write(4'd4, 32'h1111_0004, 40'd10, 40'd20, ST_SPARE7)};
    rows = {rows, row_write(4'd5, 32'h1111_0005, 40'd10, 40'd20, ST_CANCELLED)};
    rows = {rows, row_tick(40'd25, 1'b0)};
    rows = {rows, row_write(4'd0, 32'h8000_0000, 40'd30, 40'd40, ST_PENDING)};
    rows = {rows, row_write(4'd8, 32'h0000_0008, 40'd10, 40'd50, ST_PENDING)};
    rows = {rows, row_tick(40'd35, 1'b0)};
    rows = {rows, row_tick(40'd45, 1'b0)};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      issue(rows[i].item, rows[i].typed, rows[i].want);
      pause(pick_gap());
    end

    first_random = n_items;
    fill_round();
    while (n_items - first_random < RANDOM_ITEMS) begin
      steady = ($urandom_range(4, 0) == 0);
      case ($urandom_range(9, 0))
        0: fill_round();
        1, 2: noise_round();
        default: window_round();
      endcase
    end
    start <= 1'b0;

    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items (%0d table writes, %0d ticks) and %0d result beats.",
             n_items, n_writes, n_ticks, n_beats);
    $display("Actions predicted: %0d none, %0d stop, %0d miss, %0d start; %0d errors.",
             action_count[0], action_count[1], action_count[2], action_count[3], errors);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
